// ----- sv/sitda_pkg.sv -----
// shared constants and width helpers for the signed integer to decimal text block
// no dependencies; imported by every module of the block
`default_nettype none

package sitda_pkg;

  localparam int unsigned ValueBitsDefault = 32;
  localparam int unsigned InFieldBits      = 32;
  localparam int unsigned CharBits         = 6;
  localparam int unsigned OutDataBits      = 8;

  localparam logic [CharBits-1:0] CharMinus = 6'd45;
  localparam logic [CharBits-1:0] CharZero  = 6'd48;

  localparam logic [3:0] BcdAdjustMin = 4'd5;
  localparam logic [3:0] BcdAdjustAdd = 4'd3;

  // digits of 2^(bits-1); 1233/4096 approximates log10(2)
  function automatic int unsigned digits_for(input int unsigned bits);
    return ((bits - 1) * 1233) / 4096 + 1;
  endfunction

  // input data width: the 32-bit field, widened to whole bytes for wider values
  function automatic int unsigned in_data_bits(input int unsigned bits);
    return (bits > InFieldBits) ? ((bits + 7) / 8) * 8 : InFieldBits;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sitda_mag.sv -----
// input stage: takes the request, keeps the low value bits and forms sign and magnitude
// depends on sitda_pkg
`default_nettype none

module sitda_mag #(
  parameter int unsigned VALUE_BITS = sitda_pkg::ValueBitsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic [VALUE_BITS-1:0]      mag_o,
  output logic                       neg_o
);
  import sitda_pkg::*;

  logic                  valid_q, valid_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = ready_o ? valid_i : valid_q;
    neg_d   = value_i[VALUE_BITS-1];
    // magnitude fits in VALUE_BITS unsigned, most negative value included
    mag_d   = neg_d ? (~value_i + 1'b1) : value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;

endmodule

`default_nettype wire

// ----- sv/sitda_dabble.sv -----
// one shift-and-add-3 step of the binary to bcd conversion, with its own register stage
// depends on sitda_pkg
`default_nettype none

module sitda_dabble #(
  parameter int unsigned VALUE_BITS = sitda_pkg::ValueBitsDefault,
  parameter int unsigned DIGITS     = sitda_pkg::digits_for(VALUE_BITS)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [VALUE_BITS-1:0] mag_i,
  input  wire logic [DIGITS*4-1:0]   bcd_i,
  input  wire logic                  neg_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic [VALUE_BITS-1:0]      mag_o,
  output logic [DIGITS*4-1:0]        bcd_o,
  output logic                       neg_o
);
  import sitda_pkg::*;

  logic                  valid_q, valid_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [DIGITS*4-1:0]   bcd_q, bcd_d;
  logic [DIGITS*4-1:0]   adj;
  logic                  neg_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    logic [3:0] dig;
    dig = '0;
    for (int d = 0; d < DIGITS; d++) begin
      dig = bcd_i[d*4 +: 4];
      adj[d*4 +: 4] = (dig >= BcdAdjustMin) ? dig + BcdAdjustAdd : dig;
    end
  end

  always_comb begin
    valid_d = ready_o ? valid_i : valid_q;
    // next magnitude bit enters the bcd digits from below
    bcd_d   = {adj[DIGITS*4-2:0], mag_i[VALUE_BITS-1]};
    mag_d   = {mag_i[VALUE_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mag_q <= mag_d;
      bcd_q <= bcd_d;
      neg_q <= neg_i;
    end
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign bcd_o   = bcd_q;
  assign neg_o   = neg_q;

endmodule

`default_nettype wire

// ----- sv/sitda_ser.sv -----
// character serialiser: sign, then bcd digits from the leading non-zero one, with an output register
// depends on sitda_pkg
`default_nettype none

module sitda_ser #(
  parameter int unsigned DIGITS = sitda_pkg::digits_for(sitda_pkg::ValueBitsDefault)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic [DIGITS*4-1:0]           bcd_i,
  input  wire logic                          neg_i,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic [sitda_pkg::CharBits-1:0]     char_o,
  output logic                               last_o
);
  import sitda_pkg::*;

  localparam int unsigned IdxW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic                busy_q, busy_d;
  logic                neg_q, neg_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [DIGITS*4-1:0] bcd_q, bcd_d;
  logic                out_v_q, out_v_d;
  logic [CharBits-1:0] out_c_q, out_c_d;
  logic                out_l_q, out_l_d;

  logic                emit;
  logic                final_char;
  logic                load;
  logic [IdxW-1:0]     lead;
  logic [3:0]          cur_dig;

  // highest non-zero digit; zero value keeps digit 0
  always_comb begin
    lead = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_i[d*4 +: 4] != 4'd0) begin
        lead = IdxW'(d);
      end
    end
  end

  assign cur_dig    = bcd_q[idx_q*4 +: 4];
  assign emit       = busy_q && (!out_v_q || ready_i);
  assign final_char = !neg_q && (idx_q == '0);
  assign ready_o    = !busy_q || (emit && final_char);
  assign load       = valid_i && ready_o;

  always_comb begin
    busy_d  = busy_q;
    neg_d   = neg_q;
    idx_d   = idx_q;
    bcd_d   = bcd_q;
    out_v_d = out_v_q;
    out_c_d = out_c_q;
    out_l_d = out_l_q;
    if (emit) begin
      out_v_d = 1'b1;
      out_l_d = final_char;
      if (neg_q) begin
        out_c_d = CharMinus;
        neg_d   = 1'b0;
      end else begin
        out_c_d = CharZero + {2'b00, cur_dig};
        if (idx_q == '0) begin
          busy_d = 1'b0;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
    end else if (ready_i) begin
      out_v_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      neg_d  = neg_i;
      idx_d  = lead;
      bcd_d  = bcd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    idx_q   <= idx_d;
    bcd_q   <= bcd_d;
    out_c_q <= out_c_d;
    out_l_q <= out_l_d;
  end

  assign valid_o = out_v_q;
  assign char_o  = out_c_q;
  assign last_o  = out_l_q;

endmodule

`default_nettype wire

// ----- sv/signed_int_to_decimal_ascii.sv -----
// top level: signed integer to decimal ascii character stream
// depends on sitda_pkg, sitda_mag, sitda_dabble, sitda_ser
//
//  side    direction  fields (tdata / tlast)
//  s_axis  in         tdata: value (low VALUE_BITS bits used)
//  m_axis  out        tdata: char_code in [5:0], zero above; tlast: last
//
// a value passes the magnitude stage, VALUE_BITS shift-add-3 stages, the serialiser load
// and its output register before its first character is valid
// the serialiser sends one character a cycle while m_axis is ready: a value has 1 to 11
// characters at 32 bits, and that character count sets the sustained rate
// rst_ni clears all valid bits at once; a stall on m_axis backs up stage by stage
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = sitda_pkg::ValueBitsDefault
) (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire logic                                            s_axis_tvalid,
  output logic                                                 s_axis_tready,
  // value
  input  wire logic [sitda_pkg::in_data_bits(VALUE_BITS)-1:0]  s_axis_tdata,
  output logic                                                 m_axis_tvalid,
  input  wire logic                                            m_axis_tready,
  // char_code, zero fill
  output logic [sitda_pkg::OutDataBits-1:0]                    m_axis_tdata,
  // last
  output logic                                                 m_axis_tlast
);
  import sitda_pkg::*;

  localparam int unsigned Digits = digits_for(VALUE_BITS);

  logic                  valid_s [0:VALUE_BITS];
  logic                  ready_s [0:VALUE_BITS];
  logic [VALUE_BITS-1:0] mag_s   [0:VALUE_BITS];
  logic [Digits*4-1:0]   bcd_s   [0:VALUE_BITS];
  logic                  neg_s   [0:VALUE_BITS];
  logic [CharBits-1:0]   char_code;

  sitda_mag #(
    .VALUE_BITS(VALUE_BITS)
  ) u_mag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid),
    .ready_o(s_axis_tready),
    .value_i(s_axis_tdata[VALUE_BITS-1:0]),
    .valid_o(valid_s[0]),
    .ready_i(ready_s[0]),
    .mag_o  (mag_s[0]),
    .neg_o  (neg_s[0])
  );

  assign bcd_s[0] = '0;

  for (genvar i = 0; i < VALUE_BITS; i++) begin : g_dabble
    sitda_dabble #(
      .VALUE_BITS(VALUE_BITS),
      .DIGITS    (Digits)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_s[i]),
      .ready_o(ready_s[i]),
      .mag_i  (mag_s[i]),
      .bcd_i  (bcd_s[i]),
      .neg_i  (neg_s[i]),
      .valid_o(valid_s[i+1]),
      .ready_i(ready_s[i+1]),
      .mag_o  (mag_s[i+1]),
      .bcd_o  (bcd_s[i+1]),
      .neg_o  (neg_s[i+1])
    );
  end

  sitda_ser #(
    .DIGITS(Digits)
  ) u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_s[VALUE_BITS]),
    .ready_o(ready_s[VALUE_BITS]),
    .bcd_i  (bcd_s[VALUE_BITS]),
    .neg_i  (neg_s[VALUE_BITS]),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .char_o (char_code),
    .last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {(OutDataBits - CharBits)'(0), char_code};

endmodule

`default_nettype wire

// ----- sv/sitda_checker.sv -----
// port-level checks on the character stream of signed_int_to_decimal_ascii
// depends on sitda_pkg; bound to the top level below
`default_nettype none

module sitda_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [sitda_pkg::OutDataBits-1:0] m_axis_tdata,
  input wire logic                              m_axis_tlast
);
  import sitda_pkg::*;

  // a stalled character holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled character changed");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == {2'b00, CharMinus}) ||
      ((m_axis_tdata >= {2'b00, CharZero}) && (m_axis_tdata <= {2'b00, CharZero + 6'd9})))
    else $error("character outside sign and digits");

  // a sign is always followed by at least one digit
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata == {2'b00, CharMinus}) |-> !m_axis_tlast)
    else $error("minus sign flagged as last");

  // a digit straight after a sign is never a leading zero
  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tdata == {2'b00, CharMinus}) ##1
      m_axis_tvalid |-> (m_axis_tdata != {2'b00, CharZero}))
    else $error("zero after minus sign");

  // the edge that sees reset clears the output valid
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

// ----- tb/decimal_text_check.sv -----
// checker for the signed integer to decimal ascii block: predicts the character run
// of every accepted value and compares each accepted character in order
// depends on sitda_pkg for the port widths and the character codes
`timescale 1ns / 100ps

module decimal_text_check #(
  parameter int unsigned VALUE_BITS = sitda_pkg::ValueBitsDefault
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            s_axis_tvalid,
  input  logic                                            s_axis_tready,
  // value
  input  logic [sitda_pkg::in_data_bits(VALUE_BITS)-1:0]  s_axis_tdata,
  input  logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  // char_code, zero fill
  input  logic [sitda_pkg::OutDataBits-1:0]               m_axis_tdata,
  // last
  input  logic                                            m_axis_tlast,
  output int                                              mismatch_count_o,
  output int                                              chars_pending_o
);

  localparam int unsigned InBits    = sitda_pkg::in_data_bits(VALUE_BITS);
  localparam int unsigned OutBits   = sitda_pkg::OutDataBits;
  localparam int unsigned Radix     = 10;
  localparam int unsigned MaxDigits = 24;

  typedef struct packed {
    logic [sitda_pkg::CharBits-1:0] code;
    logic                           is_last;
  } text_char_t;

  text_char_t pending_chars [$];
  text_char_t want_char;
  int         mismatch_count = 0;

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // queues the text of one value: sign first, then digits most significant first
  function automatic void predict_decimal_text(input logic [InBits-1:0] word);
    logic [VALUE_BITS-1:0] raw;
    logic                  negative;
    logic [VALUE_BITS:0]   mag;
    logic [3:0]            digit_buf [MaxDigits];
    int                    n_digits;
    text_char_t            c;
    raw      = word[VALUE_BITS-1:0];
    negative = raw[VALUE_BITS-1];
    // one bit wider so the most negative value keeps its magnitude
    mag      = negative ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
    n_digits = 0;
    do begin
      digit_buf[n_digits] = 4'(mag % Radix);
      n_digits++;
      mag = mag / Radix;
    end while (mag != 0 && n_digits < MaxDigits);
    if (negative) begin
      c.code    = sitda_pkg::CharMinus;
      c.is_last = 1'b0;
      pending_chars.push_back(c);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      c.code    = sitda_pkg::CharZero + sitda_pkg::CharBits'(digit_buf[i]);
      c.is_last = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_decimal_text(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_chars.size() == 0) begin
          flag_mismatch($sformatf("character 0x%02h with no request waiting", m_axis_tdata));
        end else begin
          want_char = pending_chars.pop_front();
          if (m_axis_tdata !== OutBits'(want_char.code)) begin
            flag_mismatch($sformatf("tdata 0x%02h, wanted 0x%02h", m_axis_tdata,
                                    OutBits'(want_char.code)));
          end
          if (m_axis_tlast !== want_char.is_last) begin
            flag_mismatch($sformatf("tlast %b, wanted %b on char 0x%02h", m_axis_tlast,
                                    want_char.is_last, OutBits'(want_char.code)));
          end
        end
      end
    end
    // registered so the top samples them free of races
    mismatch_count_o <= mismatch_count;
    chars_pending_o  <= pending_chars.size();
  end

endmodule

// ----- tb/signed_int_to_decimal_ascii_tb.sv -----
// testbench top for signed_int_to_decimal_ascii: makes requests and receiver stalls
// in several idling phases and gives the verdict; checking is in decimal_text_check
// depends on sitda_pkg, signed_int_to_decimal_ascii and decimal_text_check
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;

  localparam int unsigned ValueBits      = sitda_pkg::ValueBitsDefault;
  localparam int unsigned InBits         = sitda_pkg::in_data_bits(ValueBits);
  localparam int unsigned OutBits        = sitda_pkg::OutDataBits;
  localparam int          ValuesPerPhase = 45;
  localparam int          LongHoldCycles = 400;
  localparam int          DrainCycles    = 64;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InBits-1:0]   s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutBits-1:0]  m_axis_tdata;
  logic                m_axis_tlast;

  int                  mismatch_count;
  int                  chars_pending;

  int unsigned         tx_idle_pct  = 0;
  int unsigned         rx_stall_pct = 0;
  logic                hold_toggle  = 1'b0;
  logic                hold_seen    = 1'b0;
  int                  hold_left    = 0;

  int directed_values [20] = '{
    0, 1, -1, 9, -9, 10, -10, 99, 100, -101, 7, 999999999, 1000000000, -1000000000,
    123456789, -987654321, 2147483647, 2147483646, -2147483647, 32'sh8000_0000
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(ValueBits)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  decimal_text_check #(
    .VALUE_BITS(ValueBits)
  ) text_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .chars_pending_o  (chars_pending)
  );

  // receiver: random stalls, or a long hold-off when the sender asks for one
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_toggle != hold_seen) begin
      hold_seen     <= hold_toggle;
      hold_left     <= LongHoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // valid stays high between back-to-back requests
  task automatic send_value(input logic [InBits-1:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // mostly spread over digit counts so every text length turns up, sign at random
  function automatic logic [InBits-1:0] random_value();
    int unsigned n_digits;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    if ($urandom_range(3) == 0) begin
      return InBits'($urandom);
    end
    n_digits = $urandom_range(10, 1);
    lo = 1;
    repeat (n_digits - 1) lo = lo * 10;
    hi = (n_digits == 10) ? 32'h8000_0000 : lo * 10 - 1;
    if (n_digits == 1) begin
      lo = 0;
    end
    mag = $urandom_range(hi, lo);
    if ($urandom_range(1) == 1) begin
      return InBits'(-mag);
    end
    return InBits'((mag == 32'h8000_0000) ? 32'h7fff_ffff : mag);
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_values[i]) begin
      send_value(InBits'(directed_values[i]));
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct <= 0;
          // receiver holds off while requests keep coming, so the pipe fills up
          hold_toggle  <= ~hold_toggle;
        end
        1: begin
          tx_idle_pct  = 55;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct <= 55;
        end
        default: begin
          tx_idle_pct  = 32;
          rx_stall_pct <= 32;
        end
      endcase
      repeat (ValuesPerPhase) send_value(random_value());
    end
    s_axis_tvalid <= 1'b0;

    // one edge so the pending count includes the last request
    @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- signed_int_to_decimal_ascii.f -----
sv/sitda_pkg.sv
sv/sitda_mag.sv
sv/sitda_dabble.sv
sv/sitda_ser.sv
sv/signed_int_to_decimal_ascii.sv
sv/sitda_checker.sv
tb/decimal_text_check.sv
tb/signed_int_to_decimal_ascii_tb.sv
